@@ sv/reliable_datagram_sequencer_top_macros.svh @@
// Assertion macros shared by the reliable datagram sequencer RTL.
`ifndef RELIABLE_DATAGRAM_SEQUENCER_TOP_MACROS_SVH
`define RELIABLE_DATAGRAM_SEQUENCER_TOP_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define RDS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition checked only where the previous edge was also outside reset.
`define RDS_ASSERT_AFTER_RESET(label, cond, msg) \
   `RDS_ASSERT(label, !$past(reset) |-> (cond), msg)

`endif

@@ sv/rds_pkg.sv @@
// Shared types and constants of the reliable datagram sequencer.
`timescale 1ns / 1ps

package rds_pkg;

   // Default largest packet in bytes, header included.
   localparam int MAX_PACKET_DEFAULT = 2048;

   // Reset value of the reliable queue capacity.
   localparam logic [11:0] RELIABLE_CAPACITY_RESET = 12'd2032;

   // Fixed header: two 32-bit words, plus the client port field.
   localparam logic [13:0] HEADER_BYTES      = 14'd8;
   localparam logic [13:0] PORT_FIELD_BYTES  = 14'd2;

   typedef enum logic [1:0] {
      ACT_APPEND   = 2'd0,
      ACT_TRANSMIT = 2'd1,
      ACT_RECEIVE  = 2'd2,
      ACT_NONE     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CSR_IS_CLIENT         = 2'd0,
      CSR_PORT_TAG          = 2'd1,
      CSR_RELIABLE_CAPACITY = 2'd2,
      CSR_UNUSED            = 2'd3
   } csr_index_type;

endpackage

@@ sv/reliable_datagram_sequencer_top.sv @@
// Reliable datagram sequencer: sequencing state of one alternating-bit datagram channel.
`timescale 1ns / 1ps
//
// Usage
//    The request channel (req_valid / req_stall) carries one event per transaction:
//    append reliable bytes, transmit a packet, or receive a packet header. Each
//    request yields exactly one response transaction on the rsp_ channel, in order.
//    The csr_ channel writes the client flag, the port tag and the reliable queue
//    capacity; csr_ready is always high, and writes are expected only while idle.
//    An accepted request is loaded into the input register, and the result of
//    the sequencing logic then moves from there into the output register.
//    Throughput is one transaction per cycle while the receiver does not stall,
//    since each event only needs the channel state that the previous event left.
//    When the receiver stalls, the output register holds its response and the
//    input register holds the next request; req_stall rises only when both are
//    occupied and the receiver stalls, so no transaction is lost or repeated.
//    Reset clears all channel state (outgoing sequence back to one) and restores
//    the register defaults.
//    The port tag is carried by the payload path outside this block; writes to it
//    are accepted and have no effect here.

module reliable_datagram_sequencer_top #(
   parameter int MAX_PACKET = rds_pkg::MAX_PACKET_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [11:0] req_byte_count,
   input  logic [31:0] req_seq_word,
   input  logic [31:0] req_ack_word,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_header_first,
   output logic [31:0] rsp_header_second,
   output logic        rsp_reliable_included,
   output logic [11:0] rsp_reliable_bytes,
   output logic        rsp_unreliable_included,
   output logic [12:0] rsp_packet_bytes,
   output logic        rsp_tx_refused,
   output logic        rsp_accepted,
   output logic [30:0] rsp_dropped_count,
   output logic        rsp_queue_overflow,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import rds_pkg::*;

   `include "reliable_datagram_sequencer_top_macros.svh"

   localparam logic [13:0] MaxPacketBytes = 14'(MAX_PACKET);

   // Input register.
   logic        s1_valid_ff;
   action_type  s1_action_ff;
   logic [11:0] s1_count_ff;
   logic [31:0] s1_seq_ff;
   logic [31:0] s1_ack_ff;

   // Configuration registers.
   logic        is_client_ff;
   logic [11:0] capacity_ff;

   // Channel state and its next values.
   logic [31:0] out_seq_ff,        out_seq_in;
   logic [30:0] in_seq_ff,         in_seq_in;
   logic [30:0] in_ack_ff,         in_ack_in;
   logic        in_rel_ack_bit_ff, in_rel_ack_bit_in;
   logic        in_rel_bit_ff,     in_rel_bit_in;
   logic        rel_bit_ff,        rel_bit_in;
   logic [31:0] last_rel_seq_ff,   last_rel_seq_in;
   logic [11:0] rel_length_ff,     rel_length_in;
   logic [11:0] pending_ff,        pending_in;
   logic        overflow_ff,       overflow_in;

   // Response fields computed from the input register.
   logic [31:0] hdr_first, hdr_second;
   logic        rel_incl, unrel_incl, fatal, accepted;
   logic [11:0] rel_bytes;
   logic [12:0] packet_bytes;
   logic [30:0] dropped;

   // Working values.
   logic [12:0] append_sum;
   logic        latch_block, ack_beyond, send_rel;
   logic [11:0] block_len;
   logic [13:0] base_size, total_size;
   logic [31:0] next_out_seq;
   logic [30:0] rx_seq;

   logic        rsp_valid_ff;
   logic        advance;
   logic        fire;
   logic        refused_out;

   // The output stage moves when it is empty or its response is being taken.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      out_seq_in        = out_seq_ff;
      in_seq_in         = in_seq_ff;
      in_ack_in         = in_ack_ff;
      in_rel_ack_bit_in = in_rel_ack_bit_ff;
      in_rel_bit_in     = in_rel_bit_ff;
      rel_bit_in        = rel_bit_ff;
      last_rel_seq_in   = last_rel_seq_ff;
      rel_length_in     = rel_length_ff;
      pending_in        = pending_ff;
      overflow_in       = overflow_ff;

      hdr_first    = '0;
      hdr_second   = '0;
      rel_incl     = 1'b0;
      rel_bytes    = '0;
      unrel_incl   = 1'b0;
      packet_bytes = '0;
      fatal        = 1'b0;
      accepted     = 1'b0;
      dropped      = '0;

      append_sum   = {1'b0, pending_ff} + {1'b0, s1_count_ff};
      latch_block  = (rel_length_ff == 12'd0) && (pending_ff != 12'd0);
      // The acknowledge is ahead when it exceeds the last reliable sequence as
      // signed values; a negative last sequence is always behind.
      ack_beyond   = last_rel_seq_ff[31] || (in_ack_ff > last_rel_seq_ff[30:0]);
      send_rel     = (ack_beyond && (in_rel_ack_bit_ff != rel_bit_ff)) || latch_block;
      block_len    = latch_block ? pending_ff : rel_length_ff;
      next_out_seq = out_seq_ff + 32'd1;
      base_size    = HEADER_BYTES + (is_client_ff ? PORT_FIELD_BYTES : 14'd0)
                     + (send_rel ? {2'b00, block_len} : 14'd0);
      total_size   = base_size + {2'b00, s1_count_ff};
      rx_seq       = s1_seq_ff[30:0];

      unique case (s1_action_ff)
         ACT_APPEND: begin
            if (append_sum > {1'b0, capacity_ff}) begin
               overflow_in = 1'b1;
            end else begin
               pending_in = append_sum[11:0];
            end
         end
         ACT_TRANSMIT: begin
            if (overflow_ff) begin
               fatal = 1'b1;
            end else begin
               if (latch_block) begin
                  rel_length_in = pending_ff;
                  pending_in    = '0;
                  rel_bit_in    = !rel_bit_ff;
               end
               out_seq_in = next_out_seq;
               if (send_rel) begin
                  last_rel_seq_in = next_out_seq;
               end
               hdr_first  = {send_rel, out_seq_ff[30:0]};
               hdr_second = {in_rel_bit_ff, in_seq_ff};
               rel_incl   = send_rel;
               rel_bytes  = send_rel ? block_len : 12'd0;
               if (total_size <= MaxPacketBytes) begin
                  unrel_incl   = 1'b1;
                  packet_bytes = total_size[12:0];
               end else begin
                  packet_bytes = base_size[12:0];
               end
            end
         end
         ACT_RECEIVE: begin
            // Stale or repeated sequences leave the state untouched.
            if (rx_seq > in_seq_ff) begin
               accepted = 1'b1;
               dropped  = rx_seq - in_seq_ff - 31'd1;
               if (s1_ack_ff[31] == rel_bit_ff) begin
                  rel_length_in = '0;
               end
               in_seq_in         = rx_seq;
               in_ack_in         = s1_ack_ff[30:0];
               in_rel_ack_bit_in = s1_ack_ff[31];
               if (s1_seq_ff[31]) begin
                  in_rel_bit_in = !in_rel_bit_ff;
               end
            end
         end
         ACT_NONE: begin
         end
      endcase
   end

   // Input register control.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_action_ff <= action_type'(req_action);
         s1_count_ff  <= req_byte_count;
         s1_seq_ff    <= req_seq_word;
         s1_ack_ff    <= req_ack_word;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         is_client_ff <= 1'b0;
         capacity_ff  <= RELIABLE_CAPACITY_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_IS_CLIENT:         is_client_ff <= csr_data[0];
            CSR_RELIABLE_CAPACITY: capacity_ff  <= csr_data[11:0];
            CSR_PORT_TAG:          ;
            CSR_UNUSED:            ;
         endcase
      end
   end

   // Channel state.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_seq_ff        <= 32'd1;
         in_seq_ff         <= '0;
         in_ack_ff         <= '0;
         in_rel_ack_bit_ff <= 1'b0;
         in_rel_bit_ff     <= 1'b0;
         rel_bit_ff        <= 1'b0;
         last_rel_seq_ff   <= '0;
         rel_length_ff     <= '0;
         pending_ff        <= '0;
         overflow_ff       <= 1'b0;
      end else if (fire) begin
         out_seq_ff        <= out_seq_in;
         in_seq_ff         <= in_seq_in;
         in_ack_ff         <= in_ack_in;
         in_rel_ack_bit_ff <= in_rel_ack_bit_in;
         in_rel_bit_ff     <= in_rel_bit_in;
         rel_bit_ff        <= rel_bit_in;
         last_rel_seq_ff   <= last_rel_seq_in;
         rel_length_ff     <= rel_length_in;
         pending_ff        <= pending_in;
         overflow_ff       <= overflow_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_header_first        <= hdr_first;
         rsp_header_second       <= hdr_second;
         rsp_reliable_included   <= rel_incl;
         rsp_reliable_bytes      <= rel_bytes;
         rsp_unreliable_included <= unrel_incl;
         rsp_packet_bytes        <= packet_bytes;
         rsp_tx_refused          <= fatal;
         rsp_accepted            <= accepted;
         rsp_dropped_count       <= dropped;
         rsp_queue_overflow      <= overflow_in;
      end
   end

   // A refused transmit is on offer at the output.
   assign refused_out = rsp_valid_ff && rsp_tx_refused;

   `RDS_ASSERT_AFTER_RESET(a_flag_sticky, !$past(overflow_ff) || overflow_ff, "flag cleared")
   `RDS_ASSERT_AFTER_RESET(a_seq_forward, in_seq_ff >= $past(in_seq_ff), "sequence went back")
   `RDS_ASSERT(a_refused_empty, refused_out |-> rsp_packet_bytes == '0, "refused packet")
   `RDS_ASSERT(a_refused_no_block, refused_out |-> !rsp_reliable_included, "refused block")
   `RDS_ASSERT(a_refused_flagged, refused_out |-> rsp_queue_overflow, "refused without flag")

endmodule
